// ----- design/tkcs_pkg.sv -----
// Package for the top-K column select block: field widths, register indexes
// and the command record that the front part hands to the back part.
// No dependencies.
`default_nettype none

package tkcs_pkg;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 16;
    localparam int LIMIT_W    = 6;
    localparam int STAGED_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_USER_W = 2;
    // Common width for comparing the kept count against the limit.
    localparam int CMP_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGED_COUNT = 2'd1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               active;    // non-zero value and non-zero limit
        logic               all_mode;  // limit at or above the staged count
        logic [LIMIT_W-1:0] lim;       // min(select_limit, MAX_K)
    } t_cmd;

endpackage

`default_nettype wire

// ----- design/tkcs_front.sv -----
// Front part of the top-K column select block: configuration registers and
// classification of each input item into a command. Depends on tkcs_pkg.
`default_nettype none

module tkcs_front #(
    parameter int MAX_K = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [tkcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tkcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_valid,
    input  wire logic [tkcs_pkg::IN_DATA_W-1:0]     i_data,
    input  wire logic                               i_last,
    output logic                                    o_ready,
    input  wire logic                               i_queue_full,
    output logic                                    o_push,
    output tkcs_pkg::t_cmd                          o_cmd
);
    import tkcs_pkg::*;

    localparam logic [LIMIT_W:0] MAXK_EXT = (LIMIT_W + 1)'(MAX_K);

    logic [LIMIT_W-1:0]  r_limit;
    logic [STAGED_W-1:0] r_staged;
    logic [VALUE_W-1:0]  w_value;
    logic [LIMIT_W-1:0]  w_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= '0;
            r_staged <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SELECT_LIMIT: r_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_STAGED_COUNT: r_staged <= i_cfg_data[STAGED_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_value = i_data[VALUE_W-1:0];
    assign w_lim   = ({1'b0, r_limit} < MAXK_EXT) ? r_limit : MAXK_EXT[LIMIT_W-1:0];

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_cmd.value    = w_value;
        o_cmd.index    = i_data[VALUE_W +: INDEX_W];
        o_cmd.last     = i_last;
        o_cmd.active   = (w_value != '0) && (r_limit != '0);
        o_cmd.all_mode = {{(STAGED_W-LIMIT_W){1'b0}}, r_limit} >= r_staged;
        o_cmd.lim      = w_lim;
    end

endmodule

`default_nettype wire

// ----- design/tkcs_queue.sv -----
// Short command queue between the front and back parts of the top-K column
// select block. Depends on tkcs_pkg. DEPTH must be a power of two.
`default_nettype none

module tkcs_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tkcs_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output tkcs_pkg::t_cmd      o_cmd
);
    import tkcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W:0] FILL_MAX = (PTR_W + 1)'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_fill;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_fill == FILL_MAX);
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/tkcs_back.sv -----
// Back part of the top-K column select block: the value-ordered list of kept
// entries, the index sort at the end of a pass and the result output.
// Depends on tkcs_pkg.
`default_nettype none

module tkcs_back #(
    parameter int MAX_K = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cmd_valid,
    input  wire tkcs_pkg::t_cmd                      i_cmd,
    output logic                                     o_cmd_pop,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [tkcs_pkg::INDEX_W-1:0]             m_axis_tdata,
    output logic [tkcs_pkg::OUT_USER_W-1:0]          m_axis_tuser,
    output logic                                     m_axis_tlast
);
    import tkcs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_K + 1);
    localparam int SCNT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam logic [CNT_W-1:0]  K_CNT     = CNT_W'(MAX_K);
    localparam logic [SCNT_W-1:0] SORT_LAST = SCNT_W'(MAX_K - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [VALUE_W-1:0] r_vals [MAX_K];
    logic [INDEX_W-1:0] r_idxs [MAX_K];
    logic [VALUE_W-1:0] n_vals [MAX_K];
    logic [INDEX_W-1:0] n_idxs [MAX_K];
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [1:0]         r_state, n_state;
    logic [SCNT_W-1:0]  r_sort_cnt, n_sort_cnt;

    logic [VALUE_W-1:0] w_grow_v  [MAX_K];
    logic [INDEX_W-1:0] w_grow_i  [MAX_K];
    logic [VALUE_W-1:0] w_evict_v [MAX_K];
    logic [INDEX_W-1:0] w_evict_i [MAX_K];
    logic [INDEX_W-1:0] w_sort_i  [MAX_K];
    logic [INDEX_W-1:0] w_shift_i [MAX_K];
    logic [INDEX_W:0]   w_key     [MAX_K];
    logic [MAX_K:0]     w_gt;          // slot is empty or holds a larger value
    logic [MAX_K-1:0]   w_swap;
    logic               w_take;
    logic               w_below_lim;
    logic               w_grow;
    logic               w_evict;
    logic               w_set_ovf;
    logic               w_out_fire;

    assign w_gt[MAX_K] = 1'b1;

    for (genvar p = 0; p < MAX_K; p++) begin : g_slot
        logic w_valid;
        assign w_valid  = CNT_W'(p) < r_count;
        assign w_gt[p]  = w_valid ? (i_cmd.value < r_vals[p]) : 1'b1;
        assign w_key[p] = {!w_valid, r_idxs[p]};

        // Growing insert: slots at or above the insert point move up by one.
        if (p == 0) begin : g_grow_first
            assign w_grow_v[p] = w_gt[p] ? i_cmd.value : r_vals[p];
            assign w_grow_i[p] = w_gt[p] ? i_cmd.index : r_idxs[p];
        end else begin : g_grow_rest
            assign w_grow_v[p] = !w_gt[p] ? r_vals[p] :
                                 (w_gt[p-1] ? r_vals[p-1] : i_cmd.value);
            assign w_grow_i[p] = !w_gt[p] ? r_idxs[p] :
                                 (w_gt[p-1] ? r_idxs[p-1] : i_cmd.index);
        end

        // Evicting insert: slots below the insert point move down by one,
        // dropping the smallest entry.
        if (p == MAX_K - 1) begin : g_evict_top
            assign w_evict_v[p] = !w_gt[p] ? i_cmd.value : r_vals[p];
            assign w_evict_i[p] = !w_gt[p] ? i_cmd.index : r_idxs[p];
            assign w_shift_i[p] = r_idxs[p];
            assign w_swap[p]    = 1'b0;
        end else begin : g_evict_rest
            assign w_evict_v[p] = !w_gt[p+1] ? r_vals[p+1] :
                                  (!w_gt[p] ? i_cmd.value : r_vals[p]);
            assign w_evict_i[p] = !w_gt[p+1] ? r_idxs[p+1] :
                                  (!w_gt[p] ? i_cmd.index : r_idxs[p]);
            assign w_shift_i[p] = r_idxs[p+1];
            assign w_swap[p]    = (w_key[p] > w_key[p+1]) &&
                                  (1'(p % 2) == r_sort_cnt[0]);
        end

        // One odd-even transposition step; empty slots sort to the top.
        if (p == 0) begin : g_sort_first
            assign w_sort_i[p] = w_swap[p] ? r_idxs[p+1 < MAX_K ? p+1 : p] : r_idxs[p];
        end else if (p == MAX_K - 1) begin : g_sort_top
            assign w_sort_i[p] = w_swap[p-1] ? r_idxs[p-1] : r_idxs[p];
        end else begin : g_sort_mid
            assign w_sort_i[p] = w_swap[p]   ? r_idxs[p+1] :
                                 w_swap[p-1] ? r_idxs[p-1] : r_idxs[p];
        end
    end

    assign w_take      = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_cmd_pop   = w_take;
    assign w_below_lim = {{(CMP_W-CNT_W){1'b0}}, r_count} <
                         {{(CMP_W-LIMIT_W){1'b0}}, i_cmd.lim};
    assign w_grow      = i_cmd.active && (i_cmd.all_mode ? (r_count < K_CNT) : w_below_lim);
    assign w_evict     = i_cmd.active && !i_cmd.all_mode && !w_below_lim &&
                         !w_gt[0] && (i_cmd.value != r_vals[0]);
    assign w_set_ovf   = i_cmd.active && i_cmd.all_mode && (r_count >= K_CNT);

    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = (r_count == '0) ? '0 : r_idxs[0];
    assign m_axis_tuser  = {r_ovf, r_count == '0};
    assign m_axis_tlast  = (r_count <= CNT_W'(1));
    assign w_out_fire    = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_vals     = r_vals;
        n_idxs     = r_idxs;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_state    = r_state;
        n_sort_cnt = r_sort_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (w_grow) begin
                        n_vals  = w_grow_v;
                        n_idxs  = w_grow_i;
                        n_count = r_count + 1'b1;
                    end else if (w_evict) begin
                        n_vals = w_evict_v;
                        n_idxs = w_evict_i;
                    end
                    if (w_set_ovf) n_ovf = 1'b1;
                    if (i_cmd.last) begin
                        n_state    = ST_SORT;
                        n_sort_cnt = '0;
                    end
                end
            end
            ST_SORT: begin
                n_idxs     = w_sort_i;
                n_sort_cnt = r_sort_cnt + 1'b1;
                if (r_sort_cnt == SORT_LAST) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_fire) begin
                    if (r_count <= CNT_W'(1)) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idxs  = w_shift_i;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_vals <= n_vals;
        r_idxs <= n_idxs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_state    <= ST_IDLE;
            r_sort_cnt <= '0;
        end else begin
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_state    <= n_state;
            r_sort_cnt <= n_sort_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- design/top_k_column_select_core.sv -----
// Top level of the top-K column select block: front part, command queue and
// back part. Depends on tkcs_pkg, tkcs_front, tkcs_queue and tkcs_back.
//
// The block takes column difference items (value, column index, last flag)
// and keeps a list of up to MAX_K entries ordered by value. When select_limit
// is below staged_count it keeps only the largest non-zero values, up to
// min(select_limit, MAX_K); a value equal to the smallest kept one never
// evicts it, and among equal values the later item ranks higher. Otherwise
// it keeps every non-zero value up to MAX_K and flags overflow beyond that.
// A zero select_limit ignores all items. After the item marked last, the kept
// column indices come out in ascending order, one result per cycle while
// tready is high, with tlast on the final one; a pass with nothing kept gives
// one result marked empty. Items enter a four-deep queue at one per cycle
// while it is not full; the back part, while idle, inserts one queued item
// per cycle, comparing it against all kept slots at once. After the last
// item the index sort runs MAX_K steps of odd-even transposition, then the
// results follow at one per cycle under output backpressure. Input items keep
// filling the queue meanwhile. There is no clearing pass after reset.
// Configuration registers are to be written by the user only while the block
// is idle; the block itself does not enforce this.
`default_nettype none

module top_k_column_select_core #(
    parameter int MAX_K = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration: index 0 is select_limit, index 1 is staged_count.
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [tkcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tkcs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input items.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // Fields from bit 0: diff_value[31:0], column_index[47:32].
    input  wire logic [tkcs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire logic                                s_axis_tlast,
    // Result items.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // Fields from bit 0: selected_index[15:0].
    output logic [tkcs_pkg::INDEX_W-1:0]             m_axis_tdata,
    // Fields from bit 0: none_selected[0], overflowed[1].
    output logic [tkcs_pkg::OUT_USER_W-1:0]          m_axis_tuser,
    output logic                                     m_axis_tlast
);
    import tkcs_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;
    logic w_push;
    logic w_queue_full;
    logic w_queue_valid;
    logic w_pop;

    // Registers and item classification.
    tkcs_front #(
        .MAX_K (MAX_K)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_ready      (s_axis_tready),
        .i_queue_full (w_queue_full),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    // Decouples input acceptance from the sort and output phases.
    tkcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_cmd   (w_queue_cmd)
    );

    // Kept list, index sort and result output.
    tkcs_back #(
        .MAX_K (MAX_K)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_queue_valid),
        .i_cmd         (w_queue_cmd),
        .o_cmd_pop     (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
